// ----- sv/kvmt_pkg.sv -----
// shared constants and control types for the key-value map table
// no dependencies; imported by kvmt_ctrl, kvmt_datapath and key_value_map_table_top
package kvmt_pkg;

    // default table geometry
    localparam int KVMT_ENTRIES  = 16;
    localparam int KVMT_KEY_BITS = 32;

    // fixed field widths
    localparam int CMD_W       = 2;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 31;
    localparam int READ_W      = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // result status codes
    localparam logic STS_DONE = 1'b0;
    localparam logic STS_FULL = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic compare;
        logic resolve;
        logic load_out;
    } t_kvmt_ctl;

    // datapath to controller status
    typedef struct packed {
        logic out_full;
    } t_kvmt_sts;

endpackage

// ----- sv/kvmt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module kvmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/kvmt_ctrl.sv -----
// sequencing state machine for the key-value map table
// depends on kvmt_pkg
module kvmt_ctrl
    import kvmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    input  t_kvmt_sts i_sts,
    output logic      o_in_ready,
    output t_kvmt_ctl o_ctl
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       out_free;

    assign out_free = !i_sts.out_full || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                o_ctl.compare = 1'b1;
                n_state       = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                o_ctl.resolve = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to be free
                if (out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/kvmt_datapath.sv -----
// key store, parallel match, slot selection, value ram and output register
// depends on kvmt_pkg and kvmt_ram
module kvmt_datapath
    import kvmt_pkg::*;
#(
    parameter int ENTRIES  = KVMT_ENTRIES,
    parameter int KEY_BITS = KVMT_KEY_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_kvmt_ctl            i_ctl,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [VALUE_W-1:0]   i_put_value,
    input  logic                 i_out_ready,
    output t_kvmt_sts            o_sts,
    output logic                 o_out_valid,
    output logic                 o_hit,
    output logic [READ_W-1:0]    o_read_value,
    output logic                 o_status
);

    localparam int IDX_W = $clog2(ENTRIES);

    // captured transaction
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [VALUE_W-1:0]  r_val;

    // key cells and valid marks
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_keys [ENTRIES];
    logic [ENTRIES-1:0]  r_match;

    // resolve results
    logic                r_hit;
    logic                r_status;
    logic                r_get_hit;

    // output register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [READ_W-1:0]   r_out_read;
    logic                r_out_status;

    logic                hit;
    logic                any_free;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                is_put;
    logic                is_get;
    logic                is_remove;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [VALUE_W-1:0]  ram_rdata;

    assign is_put    = (r_cmd == CMD_PUT);
    assign is_get    = (r_cmd == CMD_GET);
    assign is_remove = (r_cmd == CMD_REMOVE);

    // encode the one-hot match and find the lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_match[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
        for (int j = ENTRIES - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_idx = IDX_W'(j);
            end
        end
    end

    assign hit       = |r_match;
    assign any_free  = !(&r_valid);
    assign ram_we    = i_ctl.resolve && is_put && (hit || any_free);
    assign ram_waddr = hit ? hit_idx : free_idx;

    // capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= i_command;
            r_key <= i_key[KEY_BITS-1:0];
            r_val <= i_put_value;
        end
    end

    // parallel key compare over all cells
    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_keys[i] == r_key);
            end
        end
    end

    // key cells are written when a new key claims a slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.resolve && is_put && !hit && any_free) begin
            r_keys[free_idx] <= r_key;
        end
    end

    // valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.resolve) begin
            if (is_put && !hit && any_free) begin
                r_valid[free_idx] <= 1'b1;
            end else if (is_remove && hit) begin
                r_valid[hit_idx] <= 1'b0;
            end
        end
    end

    // per-transaction result flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.resolve) begin
            r_hit     <= hit;
            r_status  <= (is_put && !hit && !any_free) ? STS_FULL : STS_DONE;
            r_get_hit <= is_get && hit;
        end
    end

    // value store
    kvmt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_re    (i_ctl.resolve),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_hit    <= r_hit;
            r_out_status <= r_status;
            r_out_read   <= r_get_hit ? {1'b0, ram_rdata} : '1;
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_read_value   = r_out_read;
    assign o_status       = r_out_status;

endmodule

// ----- sv/key_value_map_table_top.sv -----
// key-value map table: fully associative store of unique keys with put, get and remove.
// Each transaction runs from acceptance to a loaded result through these steps: compare
// the key against every slot in parallel, pick the matching or lowest free slot and
// update it while issuing the value memory read, then take the registered value memory
// read into the output register. A new transaction is accepted only in the controller's
// idle state, once the previous one has been loaded into the output register. A stalled
// reply side holds the controller in its last step until the output register frees.
// A finished result waits in an output register while the next transaction is
// accepted. A put of a new key into a full table is dropped and flagged in status.
// Valid marks are cleared by reset, so the table is empty straight after reset with
// no clearing pass.
// depends on kvmt_pkg, kvmt_ctrl, kvmt_datapath and kvmt_ram
module key_value_map_table_top
    import kvmt_pkg::*;
#(
    parameter int ENTRIES  = KVMT_ENTRIES,
    parameter int KEY_BITS = KVMT_KEY_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // key[31:0], put_value[62:32], zero pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // command[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_value[31:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser   // hit[0], status[1]
);

    t_kvmt_ctl ctl;
    t_kvmt_sts sts;
    logic      out_hit;
    logic      out_status;

    // sequencing
    kvmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_ctl       (ctl)
    );

    // table and result path
    kvmt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_command    (s_axis_tuser[CMD_W-1:0]),
        .i_key        (s_axis_tdata[KEY_W-1:0]),
        .i_put_value  (s_axis_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_hit        (out_hit),
        .o_read_value (m_axis_tdata),
        .o_status     (out_status)
    );

    assign m_axis_tuser = {out_status, out_hit};

endmodule
